### hw/rtl/mjd_bcd_time_to_calendar_top_defines.svh
// Assertion macros shared by the date/time decoder RTL.
// Expects signals named clock and reset in the including module.
`ifndef MJD_BCD_TIME_TO_CALENDAR_TOP_DEFINES_SVH
`define MJD_BCD_TIME_TO_CALENDAR_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBTC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MBTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mbtc_pkg.sv
// Shared constants and types for the MJD/BCD to calendar decoder.
// No dependencies; used by every module of the block by scoped name.
`default_nettype none

package mbtc_pkg;

   localparam int PIPE_STAGES = 6;
   localparam int LAST_STAGE  = PIPE_STAGES - 1;

   localparam int MJD_W   = 16;
   localparam int BCD_W   = 8;
   localparam int BIN_W   = 8;
   localparam int NY_W    = 20;   // 20*mjd - 301564
   localparam int YEAR_W  = 8;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int T_W     = 9;    // day count from March 1st base, below 489

   localparam logic [MJD_W-1:0] MJD_FIRST_VALID = 16'd15079;
   localparam int YEAR_NUM_SCALE  = 20;
   localparam int YEAR_NUM_OFFSET = 301564;
   localparam int YEAR_DIV        = 7305;
   localparam int RECIP_SHIFT     = 32;
   // floor(2^32 / 7305): quotient estimate is exact or one low
   localparam logic [NY_W-1:0] YEAR_RECIP =
      NY_W'((64'd1 << RECIP_SHIFT) / 64'(YEAR_DIV));
   localparam int T_OFFSET  = 14956;
   localparam int QUAD_DAYS = 1461;

   // floor(m * 30.6001) for m = 0..15
   localparam logic [T_W-1:0] MONTH_START [16] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
   };
   localparam logic [MONTH_W-1:0] MP_JAN = 4'd14;
   localparam logic [MONTH_W-1:0] MP_FEB = 4'd15;
   localparam logic [MONTH_W-1:0] MP_BIAS = 4'd2;
   localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;

   typedef struct packed {
      logic [PIPE_STAGES-1:0] en;
      logic [PIPE_STAGES-1:0] valid;
   } pipe_ctrl_type;

   typedef struct packed {
      logic [BIN_W-1:0] second_bin;
      logic [BIN_W-1:0] minute_bin;
      logic [BIN_W-1:0] hour_bin;
   } tod_type;

   // hand-off from the year section to the month section
   typedef struct packed {
      logic             date_ok;
      logic [YEAR_W-1:0] yp;
      logic [T_W-1:0]    t;
      tod_type           tod;
   } mid_type;

   typedef struct packed {
      logic               date_in_range;
      logic [YEAR_W-1:0]  year_since_1900;
      logic [MONTH_W-1:0] month_index;
      logic [DAY_W-1:0]   day_of_month;
      tod_type            tod;
   } result_type;

   function automatic logic [BIN_W-1:0] bcd_to_bin(input logic [BCD_W-1:0] b);
      logic [BIN_W-1:0] hi;
      logic [BIN_W-1:0] lo;
      hi = BIN_W'(b[7:4]);
      lo = BIN_W'(b[3:0]);
      return (hi << 3) + (hi << 1) + lo;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/mjd_bcd_time_to_calendar_top.sv
// Top level of the MJD + BCD time-of-day to calendar decoder.
// Uses mbtc_pkg, mbtc_pipe_ctrl, mbtc_year_calc and mbtc_month_calc.
//
//   channel  dir  handshake             payload
//   req_     in   req_tvalid/tready     tdata: mjd_day, hour/minute/second BCD
//   rsp_     out  rsp_tvalid/tready     tdata: date and binary time; tuser: in-range
//
// Six register stages, one transfer in per cycle unless a stall holds the pipeline.
// Stage depth is set by the 20x20 reciprocal multiply for the year.
// Reset clears the stage valid bits only; a stall freezes each full stage
// whose successor cannot take its data, and empty stages keep filling.
`default_nettype none

module mjd_bcd_time_to_calendar_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] mjd_day, [23:16] hour_bcd, [31:24] minute_bcd, [39:32] second_bcd
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] year_since_1900, [11:8] month_index, [16:12] day_of_month,
   // [24:17] hour_bin, [32:25] minute_bin, [40:33] second_bin, [47:41] zero
   output logic [47:0]      rsp_tdata,
   // [0] date_in_range
   output logic             rsp_tuser
);

   mbtc_pkg::pipe_ctrl_type pipe;
   mbtc_pkg::mid_type       mid;
   mbtc_pkg::result_type    result;

   mbtc_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .pipe      (pipe)
   );

   mbtc_year_calc u_year (
      .clock      (clock),
      .reset      (reset),
      .pipe       (pipe),
      .mjd_day    (req_tdata[15:0]),
      .hour_bcd   (req_tdata[23:16]),
      .minute_bcd (req_tdata[31:24]),
      .second_bcd (req_tdata[39:32]),
      .mid        (mid)
   );

   mbtc_month_calc u_month (
      .clock  (clock),
      .reset  (reset),
      .pipe   (pipe),
      .mid    (mid),
      .result (result)
   );

   assign rsp_tvalid = pipe.valid[mbtc_pkg::LAST_STAGE];
   assign rsp_tdata  = {7'd0,
                        result.tod.second_bin,
                        result.tod.minute_bin,
                        result.tod.hour_bin,
                        result.day_of_month,
                        result.month_index,
                        result.year_since_1900};
   assign rsp_tuser  = result.date_in_range;

endmodule

`default_nettype wire

### hw/rtl/mbtc_pipe_ctrl.sv
// Valid bits and per-stage load enables for the decoder pipeline.
// Uses mbtc_pkg (stage count, control struct) and the assertion macros.
`default_nettype none
`include "mjd_bcd_time_to_calendar_top_defines.svh"

module mbtc_pipe_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire logic                   out_ready,
   output mbtc_pkg::pipe_ctrl_type     pipe
);

   localparam int LAST = mbtc_pkg::LAST_STAGE;

   logic [LAST:0] valid_ff;
   logic [LAST:0] valid_in;
   logic [LAST:0] rdy;

   // a stage may load when it is empty or its content moves on
   always_comb begin
      rdy[LAST] = !valid_ff[LAST] || out_ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         rdy[i] = !valid_ff[i] || rdy[i+1];
      end
      valid_in[0] = rdy[0] ? in_valid : valid_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         valid_in[i] = rdy[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready   = rdy[0];
   assign pipe.en    = rdy;
   assign pipe.valid = valid_ff;

   `MBTC_ASSERT_IMPLY(a_full_blocks_input, (&valid_ff) && !out_ready, !in_ready,
      "pipeline full and stalled but input still ready")
   `MBTC_ASSERT_NEXT(a_transfer_lands, in_valid && in_ready, valid_ff[0],
      "accepted transfer did not land in first stage")
   `MBTC_ASSERT_NEXT(a_stall_holds_last, valid_ff[LAST] && !out_ready, valid_ff[LAST],
      "stalled result dropped from output stage")

endmodule

`default_nettype wire

### hw/rtl/mbtc_year_calc.sv
// Stages 0-3: BCD conversion, year quotient by reciprocal, day count t.
// Uses mbtc_pkg constants and types, and the assertion macros.
`default_nettype none
`include "mjd_bcd_time_to_calendar_top_defines.svh"

module mbtc_year_calc (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mbtc_pkg::pipe_ctrl_type       pipe,
   input  wire logic [mbtc_pkg::MJD_W-1:0]    mjd_day,
   input  wire logic [mbtc_pkg::BCD_W-1:0]    hour_bcd,
   input  wire logic [mbtc_pkg::BCD_W-1:0]    minute_bcd,
   input  wire logic [mbtc_pkg::BCD_W-1:0]    second_bcd,
   output mbtc_pkg::mid_type                  mid
);

   localparam int MJD_W  = mbtc_pkg::MJD_W;
   localparam int NY_W   = mbtc_pkg::NY_W;
   localparam int YEAR_W = mbtc_pkg::YEAR_W;
   localparam int PROD_W = 2 * NY_W;
   localparam int REM_W  = NY_W + 1;
   localparam int YQ_W   = YEAR_W + 11;
   localparam int TW_W   = MJD_W + 1;

   // stage 0
   logic [MJD_W-1:0]      mjd0_ff;
   logic [NY_W-1:0]       ny0_ff, ny0_in;
   logic                  ok0_ff;
   mbtc_pkg::tod_type     tod0_ff, tod0_in;
   logic [NY_W:0]         ny_wide;
   // stage 1
   logic [MJD_W-1:0]      mjd1_ff;
   logic [NY_W-1:0]       ny1_ff;
   logic                  ok1_ff;
   mbtc_pkg::tod_type     tod1_ff;
   logic [YEAR_W-1:0]     qy1_ff, qy1_in;
   logic [PROD_W-1:0]     prod;
   // stage 2
   logic [MJD_W-1:0]      mjd2_ff;
   logic                  ok2_ff;
   mbtc_pkg::tod_type     tod2_ff;
   logic [YEAR_W-1:0]     yp2_ff, yp2_in;
   logic [REM_W-1:0]      rem;
   // stage 3
   mbtc_pkg::mid_type     mid3_ff, mid3_in;
   logic [YQ_W-1:0]       yq;
   logic [TW_W-1:0]       t_wide;

   always_comb begin
      ny_wide            = (NY_W+1)'(mjd_day) * (NY_W+1)'(mbtc_pkg::YEAR_NUM_SCALE)
                           - (NY_W+1)'(mbtc_pkg::YEAR_NUM_OFFSET);
      ny0_in             = ny_wide[NY_W-1:0];
      tod0_in.hour_bin   = mbtc_pkg::bcd_to_bin(hour_bcd);
      tod0_in.minute_bin = mbtc_pkg::bcd_to_bin(minute_bcd);
      tod0_in.second_bin = mbtc_pkg::bcd_to_bin(second_bcd);
   end

   always_ff @(posedge clock) begin
      if (pipe.en[0]) begin
         mjd0_ff <= mjd_day;
         ny0_ff  <= ny0_in;
         ok0_ff  <= (mjd_day >= mbtc_pkg::MJD_FIRST_VALID);
         tod0_ff <= tod0_in;
      end
   end

   // quotient estimate, exact or one short
   always_comb begin
      prod   = PROD_W'(ny0_ff) * PROD_W'(mbtc_pkg::YEAR_RECIP);
      qy1_in = prod[mbtc_pkg::RECIP_SHIFT +: YEAR_W];
   end

   always_ff @(posedge clock) begin
      if (pipe.en[1]) begin
         mjd1_ff <= mjd0_ff;
         ny1_ff  <= ny0_ff;
         ok1_ff  <= ok0_ff;
         tod1_ff <= tod0_ff;
         qy1_ff  <= qy1_in;
      end
   end

   always_comb begin
      rem    = REM_W'(ny1_ff) - REM_W'(qy1_ff) * REM_W'(mbtc_pkg::YEAR_DIV);
      yp2_in = qy1_ff + YEAR_W'(rem >= REM_W'(mbtc_pkg::YEAR_DIV));
   end

   always_ff @(posedge clock) begin
      if (pipe.en[2]) begin
         mjd2_ff <= mjd1_ff;
         ok2_ff  <= ok1_ff;
         tod2_ff <= tod1_ff;
         yp2_ff  <= yp2_in;
      end
   end

   // t = mjd - 14956 - floor(yp * 1461 / 4)
   always_comb begin
      yq              = YQ_W'(yp2_ff) * YQ_W'(mbtc_pkg::QUAD_DAYS);
      t_wide          = TW_W'(mjd2_ff) - TW_W'(mbtc_pkg::T_OFFSET) - TW_W'(yq >> 2);
      mid3_in.date_ok = ok2_ff;
      mid3_in.yp      = yp2_ff;
      mid3_in.t       = t_wide[mbtc_pkg::T_W-1:0];
      mid3_in.tod     = tod2_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe.en[3]) begin
         mid3_ff <= mid3_in;
      end
   end

   assign mid = mid3_ff;

   `MBTC_ASSERT_IMPLY(a_rem_small, pipe.valid[1] && ok1_ff,
      rem < REM_W'(2 * mbtc_pkg::YEAR_DIV), "year quotient estimate off by more than one")
   `MBTC_ASSERT_IMPLY(a_year_range, pipe.valid[2] && ok2_ff, yp2_ff <= YEAR_W'(138),
      "year quotient out of range")

endmodule

`default_nettype wire

### hw/rtl/mbtc_month_calc.sv
// Stages 4-5: month quotient by table compare, then day, year and month.
// Uses mbtc_pkg constants and types, and the assertion macros.
`default_nettype none
`include "mjd_bcd_time_to_calendar_top_defines.svh"

module mbtc_month_calc (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire mbtc_pkg::pipe_ctrl_type  pipe,
   input  wire mbtc_pkg::mid_type        mid,
   output mbtc_pkg::result_type          result
);

   localparam int MONTH_W = mbtc_pkg::MONTH_W;
   localparam int YEAR_W  = mbtc_pkg::YEAR_W;
   localparam int T_W     = mbtc_pkg::T_W;

   mbtc_pkg::mid_type    mid4_ff;
   logic [MONTH_W-1:0]   mp4_ff, mp4_in;
   mbtc_pkg::result_type res5_ff, res5_in;
   logic [T_W-1:0]       d;
   logic                 k;

   // M' = number of months m >= 1 whose start lies below t
   // (fractions of m*30.6001 never exceed .9, so floor compare is exact)
   always_comb begin
      mp4_in = '0;
      for (int m = 1; m < 16; m++) begin
         mp4_in = mp4_in + MONTH_W'(mbtc_pkg::MONTH_START[m] < mid.t);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.en[4]) begin
         mid4_ff <= mid;
         mp4_ff  <= mp4_in;
      end
   end

   always_comb begin
      d                       = mid4_ff.t - mbtc_pkg::MONTH_START[mp4_ff];
      k                       = (mp4_ff == mbtc_pkg::MP_JAN) || (mp4_ff == mbtc_pkg::MP_FEB);
      res5_in.tod             = mid4_ff.tod;
      res5_in.date_in_range   = mid4_ff.date_ok;
      res5_in.year_since_1900 = '0;
      res5_in.month_index     = '0;
      res5_in.day_of_month    = '0;
      if (mid4_ff.date_ok) begin
         res5_in.year_since_1900 = mid4_ff.yp + YEAR_W'(k);
         res5_in.month_index     = mp4_ff - mbtc_pkg::MP_BIAS
                                   - (k ? mbtc_pkg::MONTHS_PER_YEAR : MONTH_W'(0));
         res5_in.day_of_month    = d[mbtc_pkg::DAY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe.en[5]) begin
         res5_ff <= res5_in;
      end
   end

   assign result = res5_ff;

   `MBTC_ASSERT_IMPLY(a_month_day_range, pipe.valid[5] && res5_ff.date_in_range,
      (res5_ff.month_index <= MONTH_W'(11)) && (res5_ff.day_of_month != '0),
      "decoded month or day out of range")

endmodule

`default_nettype wire
